>>> hdl/mtsp_pkg.sv
package mtsp_pkg;

    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int GAIN_FRAC_BITS_DEF = 15;

    localparam int PAN_BITS       = 16;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 16;

    // register indexes on the configuration channel
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_POSITION = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_LAW      = 2'd1;

    typedef enum logic [1:0] {
        LAW_LINEAR = 2'd0,
        LAW_CPOW   = 2'd1,
        LAW_SQRT   = 2'd2,
        LAW_FIXED  = 2'd3
    } pan_law_t;

    typedef enum logic [3:0] {
        G_IDLE,
        G_SQUARE,
        G_SQUARE_WB,
        G_HORNER_MUL,
        G_HORNER_ACC,
        G_FINAL_MUL,
        G_SIN_DONE,
        G_SQRT_STEP,
        G_SQRT_DONE
    } gain_state_t;

    typedef struct packed {
        logic                start;
        logic [PAN_BITS-1:0] pan;
        pan_law_t            law;
    } gain_req_t;

    // sin(pi/2 * w/65536) odd polynomial, Q30 coefficients
    localparam logic signed [31:0] C_A1 = 32'sd1686629713;
    localparam logic signed [31:0] C_A3 = 32'sd693598668;
    localparam logic signed [31:0] C_A5 = 32'sd85569306;
    localparam logic signed [31:0] C_A7 = 32'sd5026995;
    localparam logic signed [31:0] C_A9 = 32'sd172272;

    // constant added after each Horner multiply
    function automatic logic signed [31:0] horner_coef(input logic [1:0] step);
        logic signed [31:0] c;
        case (step)
            2'd0:    c = -C_A7;
            2'd1:    c = C_A5;
            2'd2:    c = -C_A3;
            default: c = C_A1;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/mtsp_gain_unit.sv
module mtsp_gain_unit #(
    parameter int GAIN_FRAC_BITS = mtsp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mtsp_pkg::gain_req_t   req,
    output logic                  busy,
    output logic [GAIN_FRAC_BITS:0] left_gain,
    output logic [GAIN_FRAC_BITS:0] right_gain
);
    import mtsp_pkg::*;

    localparam int GW       = GAIN_FRAC_BITS + 1;
    localparam int NW       = 2 * GAIN_FRAC_BITS + 1;
    localparam int SQ_SHIFT = 2 * GAIN_FRAC_BITS - 16;
    localparam int LW       = 17 + GAIN_FRAC_BITS + 1;

    localparam logic [GW-1:0] GAIN_ONE   = GW'(1) << GAIN_FRAC_BITS;
    localparam logic [GW-1:0] GAIN_FIXED =
        GW'((707 * (1 << GAIN_FRAC_BITS) + 500) / 1000);
    localparam logic [NW-1:0] SQ_BIT_TOP = NW'(1) << (NW - 1);
    localparam logic [30:0]   SIN_ONE    = 31'h4000_0000;
    localparam logic [31:0]   SIN_HALF   = 32'(1) << (29 - GAIN_FRAC_BITS);

    gain_state_t        state_reg, state_next;
    logic               side_reg, side_next;      // 0 right, 1 left
    logic [16:0]        w_reg, w_next;
    logic [30:0]        s_reg, s_next;
    logic signed [31:0] r_reg, r_next;
    logic [1:0]         k_reg, k_next;
    logic [62:0]        prod_reg, prod_next;
    logic [NW-1:0]      sq_n_reg, sq_n_next;
    logic [NW-1:0]      sq_r_reg, sq_r_next;
    logic [NW-1:0]      sq_bit_reg, sq_bit_next;
    logic [GW-1:0]      left_gain_reg, left_gain_next;
    logic [GW-1:0]      right_gain_reg, right_gain_next;

    logic [16:0]        u;
    logic [16:0]        u_left;
    logic [LW-1:0]      lin_sum;
    logic [GW-1:0]      lin_right;
    logic [31:0]        mag_r;
    logic [31:0]        mul_a;
    logic [30:0]        mul_b;
    logic signed [34:0] term;
    logic signed [34:0] horner_sum;
    logic [32:0]        res_mag;
    logic [30:0]        res_clamped;
    logic [31:0]        res_rounded;
    logic [GW-1:0]      sin_gain;
    logic [NW-1:0]      sq_trial;
    logic [GW-1:0]      sqrt_gain;
    logic               right_side_done;

    // offset-binary pan: u = pan + 32768
    assign u      = {1'b0, ~req.pan[PAN_BITS-1], req.pan[PAN_BITS-2:0]};
    assign u_left = 17'h1_0000 - u;

    assign lin_sum   = (LW'(u) << GAIN_FRAC_BITS) + LW'(32768);
    assign lin_right = lin_sum[16 +: GW];

    assign mag_r = r_reg[31] ? 32'(-r_reg) : 32'(r_reg);

    always_comb begin
        case (state_reg)
            G_SQUARE: begin
                mul_a = 32'(w_reg);
                mul_b = 31'(w_reg);
            end
            G_HORNER_MUL: begin
                mul_a = mag_r;
                mul_b = s_reg;
            end
            default: begin
                mul_a = mag_r;
                mul_b = 31'(w_reg);
            end
        endcase
    end

    // truncation toward zero: shift the magnitude, then restore the sign
    assign term = r_reg[31] ? -$signed({2'b00, prod_reg[62:30]})
                            :  $signed({2'b00, prod_reg[62:30]});
    assign horner_sum = term + 35'(horner_coef(k_reg));

    assign res_mag = prod_reg[48:16];
    always_comb begin
        if (r_reg[31]) begin
            res_clamped = '0;
        end else if (res_mag > 33'(SIN_ONE)) begin
            res_clamped = SIN_ONE;
        end else begin
            res_clamped = res_mag[30:0];
        end
    end
    assign res_rounded = 32'(res_clamped) + SIN_HALF;
    assign sin_gain    = GW'(res_rounded >> (30 - GAIN_FRAC_BITS));

    assign sq_trial  = sq_r_reg + sq_bit_reg;
    assign sqrt_gain = GW'(sq_r_reg + NW'(sq_n_reg > sq_r_reg));

    assign right_side_done = !side_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            G_IDLE: begin
                if (req.start) begin
                    case (req.law)
                        LAW_CPOW: state_next = G_SQUARE;
                        LAW_SQRT: state_next = G_SQRT_STEP;
                        default:  state_next = G_IDLE;
                    endcase
                end
            end
            G_SQUARE:     state_next = G_SQUARE_WB;
            G_SQUARE_WB:  state_next = G_HORNER_MUL;
            G_HORNER_MUL: state_next = G_HORNER_ACC;
            G_HORNER_ACC: state_next = (k_reg == 2'd3) ? G_FINAL_MUL : G_HORNER_MUL;
            G_FINAL_MUL:  state_next = G_SIN_DONE;
            G_SIN_DONE:   state_next = right_side_done ? G_SQUARE : G_IDLE;
            G_SQRT_STEP:  state_next = sq_bit_reg[0] ? G_SQRT_DONE : G_SQRT_STEP;
            G_SQRT_DONE:  state_next = right_side_done ? G_SQRT_STEP : G_IDLE;
            default:      state_next = G_IDLE;
        endcase
    end

    // datapath updates
    always_comb begin
        side_next       = side_reg;
        w_next          = w_reg;
        s_next          = s_reg;
        r_next          = r_reg;
        k_next          = k_reg;
        prod_next       = prod_reg;
        sq_n_next       = sq_n_reg;
        sq_r_next       = sq_r_reg;
        sq_bit_next     = sq_bit_reg;
        left_gain_next  = left_gain_reg;
        right_gain_next = right_gain_reg;
        case (state_reg)
            G_IDLE: begin
                side_next   = 1'b0;
                w_next      = u;
                sq_n_next   = NW'(u) << SQ_SHIFT;
                sq_r_next   = '0;
                sq_bit_next = SQ_BIT_TOP;
                if (req.start) begin
                    case (req.law)
                        LAW_LINEAR: begin
                            right_gain_next = lin_right;
                            left_gain_next  = GAIN_ONE - lin_right;
                        end
                        LAW_FIXED: begin
                            right_gain_next = GAIN_FIXED;
                            left_gain_next  = GAIN_FIXED;
                        end
                        default: ;
                    endcase
                end
            end
            G_SQUARE, G_HORNER_MUL, G_FINAL_MUL: begin
                prod_next = 63'(mul_a) * 63'(mul_b);
            end
            G_SQUARE_WB: begin
                s_next = prod_reg[32:2];
                r_next = C_A9;
                k_next = 2'd0;
            end
            G_HORNER_ACC: begin
                r_next = horner_sum[31:0];
                k_next = k_reg + 2'd1;
            end
            G_SIN_DONE: begin
                if (right_side_done) begin
                    right_gain_next = sin_gain;
                    side_next       = 1'b1;
                    w_next          = u_left;
                end else begin
                    left_gain_next = sin_gain;
                end
            end
            G_SQRT_STEP: begin
                if (sq_n_reg >= sq_trial) begin
                    sq_n_next = sq_n_reg - sq_trial;
                    sq_r_next = (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_next = sq_r_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
            end
            G_SQRT_DONE: begin
                if (right_side_done) begin
                    right_gain_next = sqrt_gain;
                    side_next       = 1'b1;
                    sq_n_next       = NW'(u_left) << SQ_SHIFT;
                    sq_r_next       = '0;
                    sq_bit_next     = SQ_BIT_TOP;
                end else begin
                    left_gain_next = sqrt_gain;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
        end else begin
            state_reg <= state_next;
        end
        side_reg       <= side_next;
        w_reg          <= w_next;
        s_reg          <= s_next;
        r_reg          <= r_next;
        k_reg          <= k_next;
        prod_reg       <= prod_next;
        sq_n_reg       <= sq_n_next;
        sq_r_reg       <= sq_r_next;
        sq_bit_reg     <= sq_bit_next;
        left_gain_reg  <= left_gain_next;
        right_gain_reg <= right_gain_next;
    end

    assign busy       = (state_reg != G_IDLE);
    assign left_gain  = left_gain_reg;
    assign right_gain = right_gain_reg;

    a_start_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == G_IDLE)
        else $error("gain recompute requested while busy");

    a_sqrt_bit_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == G_SQRT_STEP |-> $onehot(sq_bit_reg))
        else $error("square root bit lost");

endmodule

>>> hdl/mtsp_gain_apply.sv
module mtsp_gain_apply #(
    parameter int SAMPLE_BITS    = mtsp_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = mtsp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic [GAIN_FRAC_BITS:0]       gain,
    output logic signed [SAMPLE_BITS-1:0] scaled
);
    import mtsp_pkg::*;

    localparam int PW = SAMPLE_BITS + GAIN_FRAC_BITS + 2;

    localparam logic signed [PW-1:0] SAT_HI   = PW'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [PW-1:0] SAT_LO   = -SAT_HI - PW'(1);
    localparam logic signed [PW-1:0] NEG_BIAS = PW'((1 << GAIN_FRAC_BITS) - 1);

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] biased;
    logic signed [PW-1:0] shifted;

    assign prod = PW'(sample) * PW'($signed({1'b0, gain}));
    // bias negatives so the arithmetic shift truncates toward zero
    assign biased  = prod[PW-1] ? prod + NEG_BIAS : prod;
    assign shifted = biased >>> GAIN_FRAC_BITS;

    always_comb begin
        if (shifted > SAT_HI) begin
            scaled = SAT_HI[SAMPLE_BITS-1:0];
        end else if (shifted < SAT_LO) begin
            scaled = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            scaled = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

>>> hdl/mtsp_datapath.sv
module mtsp_datapath #(
    parameter int SAMPLE_BITS    = mtsp_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = mtsp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          enable,
    input  logic [GAIN_FRAC_BITS:0]       left_gain,
    input  logic [GAIN_FRAC_BITS:0]       right_gain,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic                          in_last,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_left,
    output logic signed [SAMPLE_BITS-1:0] out_right,
    output logic                          out_last
);
    import mtsp_pkg::*;

    logic                          in_valid_reg, in_valid_next;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                          in_last_reg;
    logic                          out_valid_reg, out_valid_next;
    logic signed [SAMPLE_BITS-1:0] out_left_reg;
    logic signed [SAMPLE_BITS-1:0] out_right_reg;
    logic                          out_last_reg;

    logic                          slot_free;
    logic                          advance;
    logic                          accept;
    logic signed [SAMPLE_BITS-1:0] left_scaled;
    logic signed [SAMPLE_BITS-1:0] right_scaled;

    assign slot_free = !out_valid_reg || out_ready;
    assign advance   = in_valid_reg && slot_free;
    assign in_ready  = enable && (!in_valid_reg || slot_free);
    assign accept    = in_valid && in_ready;

    mtsp_gain_apply #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_left (
        .sample (in_sample_reg),
        .gain   (left_gain),
        .scaled (left_scaled)
    );

    mtsp_gain_apply #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_right (
        .sample (in_sample_reg),
        .gain   (right_gain),
        .scaled (right_scaled)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        if (accept) begin
            in_sample_reg <= in_sample;
            in_last_reg   <= in_last;
        end
        if (advance) begin
            out_left_reg  <= left_scaled;
            out_right_reg <= right_scaled;
            out_last_reg  <= in_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign out_last  = out_last_reg;

    a_accept_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> in_valid_reg)
        else $error("accepted transaction not held in input stage");

    a_advance_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("input stage moved without a result");

endmodule

>>> hdl/mono_to_stereo_panner.sv
// Mono to stereo panner.
// s_ side: one signed mono sample per transaction in s_tdata, block end
// flag on s_tlast. m_ side: left and right samples in m_tdata (left in the
// low half), s_tlast copied to m_tlast.
// Pan position (register 0, signed Q1.15) and pan law (register 1: linear,
// constant power, square root, fixed 0.707) are written on the cfg_ port.
// Writes to other indexes are ignored.
// An accepted sample is held in the input register, then scaled into the
// output register, whose valid flag drives m_tvalid.
// Throughput: one sample per cycle while m_tready is high and no recompute
// runs; input and output registers let a sample enter while a result waits.
// Each register write, and reset, starts a gain recompute in a shared
// multiply/iterate unit; s_tready and cfg_ready stay low meanwhile:
// linear and fixed are set straight from the idle state, constant power
// runs a Horner polynomial over one 32x31 multiplier (both sides), square
// root takes one result bit per cycle (both sides).
// Reset (aresetn low, synchronous) empties the pipeline, restores center
// pan and constant-power law, then runs that recompute.
// When m_tready is low the result holds and s_tready drops once both
// stages are full; nothing is dropped.
module mono_to_stereo_panner #(
    parameter int SAMPLE_BITS    = mtsp_pkg::SAMPLE_BITS_DEF,
    parameter int GAIN_FRAC_BITS = mtsp_pkg::GAIN_FRAC_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // s_tdata: mono_sample
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]        s_tdata,
    input  logic                                    s_tlast,
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // m_tdata: left_sample, right_sample
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]      m_tdata,
    output logic                                    m_tlast,
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [mtsp_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mtsp_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import mtsp_pkg::*;

    localparam int M_TDATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    logic [PAN_BITS-1:0] pan_position_reg, pan_position_next;
    pan_law_t            pan_law_reg, pan_law_next;
    logic                start_reg, start_next;

    logic                          cfg_accept;
    logic                          gain_busy;
    logic                          gains_ready;
    gain_req_t                     gain_req;
    logic [GAIN_FRAC_BITS:0]       left_gain;
    logic [GAIN_FRAC_BITS:0]       right_gain;
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;

    assign gains_ready = !gain_busy && !start_reg;
    assign cfg_ready   = gains_ready;
    assign cfg_accept  = cfg_valid && cfg_ready;

    always_comb begin
        pan_position_next = pan_position_reg;
        pan_law_next      = pan_law_reg;
        start_next        = cfg_accept;
        if (cfg_accept) begin
            case (cfg_index)
                REG_PAN_POSITION: pan_position_next = cfg_data[PAN_BITS-1:0];
                REG_PAN_LAW:      pan_law_next      = pan_law_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_position_reg <= '0;
            pan_law_reg      <= LAW_CPOW;
            start_reg        <= 1'b1;
        end else begin
            pan_position_reg <= pan_position_next;
            pan_law_reg      <= pan_law_next;
            start_reg        <= start_next;
        end
    end

    assign gain_req.start = start_reg;
    assign gain_req.pan   = pan_position_reg;
    assign gain_req.law   = pan_law_reg;

    mtsp_gain_unit #(
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_gain_unit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (gain_req),
        .busy       (gain_busy),
        .left_gain  (left_gain),
        .right_gain (right_gain)
    );

    mtsp_datapath #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enable     (gains_ready),
        .left_gain  (left_gain),
        .right_gain (right_gain),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_sample  ($signed(s_tdata[SAMPLE_BITS-1:0])),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_left   (out_left),
        .out_right  (out_right),
        .out_last   (m_tlast)
    );

    assign m_tdata = M_TDATA_BITS'({out_right, out_left});

    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_accept |=> !s_tready)
        else $error("sample accepted before gains were recomputed");

endmodule

>>> tb/tb.sv
module tb;
    import mtsp_pkg::*;

    localparam int  CYCLE_LIMIT  = 200000;
    localparam int  RANDOM_ITEMS = 1680;
    localparam int  HOLD_CYCLES  = 80;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  PRINT_CAP    = 60;

    // indexes with no register behind them
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_3 = 2'd3;

    // Q30 coefficients of the odd sine polynomial
    localparam longint SIN_C1 = 1686629713;
    localparam longint SIN_C3 = 693598668;
    localparam longint SIN_C5 = 85569306;
    localparam longint SIN_C7 = 5026995;
    localparam longint SIN_C9 = 172272;

    localparam logic [15:0] UNITY_GAIN = 16'd32768;

    typedef struct packed {
        logic        last;
        logic [15:0] right;
        logic [15:0] left;
    } stereo_t;

    typedef enum logic { ROW_WRITE, ROW_SAMPLE } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [1:0]  idx;
        logic [15:0] data;
        logic        last;
        logic        known;
        logic [15:0] want_l;
        logic [15:0] want_r;
    } stim_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic [15:0] s_tdata   = '0;   // mono_sample
    logic        s_tlast   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;          // left_sample, right_sample
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // predictor state
    logic signed [15:0] pan_q15;
    pan_law_t           law_sel;
    logic [15:0]        gain_l;
    logic [15:0]        gain_r;

    stereo_t   stereo_due[$];
    stim_row_t stim_rows[$];
    stereo_t   oldest_due;

    int  mismatches  = 0;
    int  cycle_count = 0;
    bit  no_gaps     = 1'b0;
    bit  hold_req    = 1'b0;

    mono_to_stereo_panner DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // (a * b) >> sh, magnitude truncated so the result rounds toward zero
    function automatic longint trunc_mul(input longint a, input longint unsigned b,
                                         input int sh);
        longint unsigned mag;
        mag = (a < 0) ? -a : a;
        mag = (mag * b) >> sh;
        return (a < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // sin(pi/2 * w/65536), w in 0..65536, as a Q15 gain
    function automatic logic [15:0] sine_gain(input longint unsigned w);
        longint unsigned sq;
        longint acc;
        sq  = (w * w) >> 2;
        acc = SIN_C9;
        acc = trunc_mul(acc, sq, 30) - SIN_C7;
        acc = trunc_mul(acc, sq, 30) + SIN_C5;
        acc = trunc_mul(acc, sq, 30) - SIN_C3;
        acc = trunc_mul(acc, sq, 30) + SIN_C1;
        acc = trunc_mul(acc, w, 16);
        if (acc < 0) acc = 0;
        if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
        return 16'((acc + (longint'(1) << 14)) >> 15);
    endfunction

    function automatic logic [15:0] round_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = longint'(1) << 40;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        if (n > root) root++;
        return 16'(root);
    endfunction

    function automatic void recompute_gains();
        longint unsigned u;
        u = longint'(pan_q15) + 32768;
        case (law_sel)
            LAW_LINEAR: begin
                gain_r = 16'(((u << 15) + 32768) >> 16);
                gain_l = UNITY_GAIN - gain_r;
            end
            LAW_CPOW: begin
                gain_r = sine_gain(u);
                gain_l = sine_gain(65536 - u);
            end
            LAW_SQRT: begin
                gain_r = round_sqrt(u << 14);
                gain_l = round_sqrt((65536 - u) << 14);
            end
            default: begin
                gain_r = 16'((707 * 32768 + 500) / 1000);
                gain_l = gain_r;
            end
        endcase
    endfunction

    function automatic logic [15:0] pan_sample(input logic signed [15:0] x,
                                               input logic [15:0] g);
        longint y;
        y = trunc_mul(longint'(x), {48'b0, g}, 15);
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        return y[15:0];
    endfunction

    function automatic void put_write(input logic [1:0] idx, input logic [15:0] val);
        stim_rows.push_back('{ROW_WRITE, idx, val, 1'b0, 1'b0, 16'h0, 16'h0});
    endfunction

    function automatic void put_sample(input logic [15:0] smp, input logic last);
        stim_rows.push_back('{ROW_SAMPLE, 2'd0, smp, last, 1'b0, 16'h0, 16'h0});
    endfunction

    function automatic void put_known(input logic [15:0] smp, input logic last,
                                      input logic [15:0] l, input logic [15:0] r);
        stim_rows.push_back('{ROW_SAMPLE, 2'd0, smp, last, 1'b1, l, r});
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_pan();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic report(input string what, input logic [15:0] got,
                          input logic [15:0] want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic send_sample(input logic [15:0] smp, input logic last,
                               input logic known, input logic [15:0] want_l,
                               input logic [15:0] want_r);
        int gap;
        stereo_t due;
        gap = (no_gaps || hold_req) ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        due.last  = last;
        due.left  = known ? want_l : pan_sample(smp, gain_l);
        due.right = known ? want_r : pan_sample(smp, gain_r);
        stereo_due.push_back(due);
    endtask

    // registers change only with the pipeline drained
    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (stereo_due.size() != 0) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_PAN_POSITION: begin
                pan_q15 = val;
                recompute_gains();
            end
            REG_PAN_LAW: begin
                law_sel = pan_law_t'(val[1:0]);
                recompute_gains();
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (stereo_due.size() == 0) begin
                report("unexpected transaction", m_tdata[15:0], 16'h0);
            end else begin
                oldest_due = stereo_due.pop_front();
                if (m_tdata[15:0] !== oldest_due.left)
                    report("left_sample", m_tdata[15:0], oldest_due.left);
                if (m_tdata[31:16] !== oldest_due.right)
                    report("right_sample", m_tdata[31:16], oldest_due.right);
                if (m_tlast !== oldest_due.last)
                    report("block_end_out", {15'b0, m_tlast}, {15'b0, oldest_due.last});
            end
        end
    end

    initial begin : sink
        int stall;
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                // long back-pressure: the block has to fill and stall its input
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, 6);
                if (stall > 0) begin
                    @(negedge aclk);
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(negedge aclk);
                end
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin : stimulus
        int phase;
        int sent;
        int run_len;
        pan_q15 = 16'sd0;
        law_sel = LAW_CPOW;
        recompute_gains();

        // center, constant power (state after reset)
        put_sample(16'h7FFF, 1'b0);
        put_sample(16'h8000, 1'b0);
        put_sample(16'h0000, 1'b0);
        put_sample(16'h0001, 1'b0);
        put_sample(16'hFFFF, 1'b0);
        put_sample(16'h5555, 1'b1);
        // fixed 0.707 on both sides
        put_write(REG_PAN_LAW, {14'b0, LAW_FIXED});
        put_known(16'h7FFF, 1'b0, 16'd23166, 16'd23166);
        put_known(16'h8000, 1'b0, -16'sd23167, -16'sd23167);
        put_known(16'h0000, 1'b1, 16'd0, 16'd0);
        // linear, full left
        put_write(REG_PAN_POSITION, 16'h8000);
        put_write(REG_PAN_LAW, {14'b0, LAW_LINEAR});
        put_known(16'h7FFF, 1'b0, 16'h7FFF, 16'h0000);
        put_known(16'h8000, 1'b1, 16'h8000, 16'h0000);
        // linear, full right rounds up to unity
        put_write(REG_PAN_POSITION, 16'h7FFF);
        put_known(16'h7FFF, 1'b0, 16'h0000, 16'h7FFF);
        put_known(16'h8000, 1'b0, 16'h0000, 16'h8000);
        // upper data bits set on the law register, masked to square root
        put_write(REG_PAN_LAW, {14'h3FFF, LAW_SQRT});
        put_sample(16'h7FFF, 1'b0);
        put_sample(16'h8000, 1'b0);
        put_sample(16'hAAAA, 1'b1);
        // writes to spare indexes change nothing
        put_write(REG_SPARE_2, 16'hFFFF);
        put_write(REG_SPARE_3, 16'h0000);
        put_sample(16'h7FFF, 1'b0);
        // constant power at both ends
        put_write(REG_PAN_POSITION, 16'h8000);
        put_write(REG_PAN_LAW, {14'b0, LAW_CPOW});
        put_sample(16'h7FFF, 1'b0);
        put_sample(16'h8000, 1'b1);
        put_write(REG_PAN_POSITION, 16'h7FFF);
        put_sample(16'h7FFF, 1'b1);

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE)
                write_reg(stim_rows[i].idx, stim_rows[i].data);
            else
                send_sample(stim_rows[i].data, stim_rows[i].last, stim_rows[i].known,
                            stim_rows[i].want_l, stim_rows[i].want_r);
        end

        phase = 0;
        sent  = 0;
        while (sent < RANDOM_ITEMS) begin
            phase++;
            case ($urandom_range(0, 4))
                0: write_reg(REG_PAN_POSITION, pick_pan());
                1: write_reg(REG_PAN_LAW, 16'($urandom));
                2: begin
                    write_reg(REG_PAN_POSITION, pick_pan());
                    write_reg(REG_PAN_LAW, 16'($urandom));
                end
                3: begin
                    write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                              16'($urandom));
                    write_reg(REG_PAN_LAW, 16'($urandom));
                end
                default: ;
            endcase
            no_gaps = (phase % 5 == 1);
            run_len = $urandom_range(10, 60);
            if (phase == 3) begin
                run_len  = 150;
                hold_req = 1'b1;
            end
            repeat (run_len) begin
                send_sample(pick_sample(), $urandom_range(0, 7) == 0, 1'b0, 16'h0, 16'h0);
                sent++;
            end
        end
        no_gaps = 1'b0;

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (stereo_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
